FILE: design/overwriting_trace_ring_buffer_defines.svh
`ifndef OVERWRITING_TRACE_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_TRACE_RING_BUFFER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define OTRB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trace buffer check failed");

// Consequence in the cycle after the condition.
`define OTRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trace buffer check failed");

`endif

FILE: design/otrb_pkg.sv
`default_nettype none

package otrb_pkg;

   localparam int DEPTH      = 1024;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int SIZE_W     = ADDR_W + 1;
   localparam int MAX_READ   = 64;
   localparam int CNT_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int PEAK_W     = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Word index of the size register on the configuration port.
   localparam logic REG_BUF_SIZE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_EMPTY
   } state_type;

   // Printable ASCII and newline are captured; everything else is dropped.
   function automatic logic is_kept(input logic [CHAR_W-1:0] ch);
      return ((ch >= CH_SPACE) && (ch < CH_DEL)) || (ch == CH_NEWLINE);
   endfunction

endpackage

`default_nettype wire

FILE: design/overwriting_trace_ring_buffer.sv
// Write transaction: accepted while idle, a kept byte stored at that edge; it gives no result.
// Read transaction: the fetch state reads the first byte, the load state registers it as
// the result, then one byte per cycle while the output is not stalled from the single read
// port of the byte memory; the input stays blocked until the last byte is loaded. An empty
// read gives its one result from the empty state. Synchronous active-high reset clears the
// size, indices, peak fill and control; the byte memory is not cleared.
`default_nettype none

module overwriting_trace_ring_buffer (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_type,
   input  wire  [otrb_pkg::CHAR_W-1:0]          req_char_in,
   input  wire  [otrb_pkg::CNT_W-1:0]           req_read_count,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [otrb_pkg::CHAR_W-1:0]          rsp_data_out,
   output logic                                 rsp_byte_valid,
   output logic                                 rsp_last,
   output logic [otrb_pkg::PEAK_W-1:0]          rsp_peak_fill,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [otrb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [otrb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [otrb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int ADDR_W = otrb_pkg::ADDR_W;
   localparam int SIZE_W = otrb_pkg::SIZE_W;
   localparam int CNT_W  = otrb_pkg::CNT_W;
   localparam int CHAR_W = otrb_pkg::CHAR_W;
   localparam int PEAK_W = otrb_pkg::PEAK_W;
   localparam int CSR_ADDR_W_TOP = otrb_pkg::CSR_ADDR_W - 1;

   logic [CHAR_W-1:0] mem [otrb_pkg::DEPTH];
   logic [CHAR_W-1:0] mem_q_ff;

   otrb_pkg::state_type state_ff, state_in;

   logic [SIZE_W-1:0] buf_size_ff, buf_size_in;
   logic [ADDR_W-1:0] wi_ff, wi_in;
   logic [ADDR_W-1:0] ri_ff, ri_in;
   logic [PEAK_W-1:0] max_fill_ff, max_fill_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [PEAK_W-1:0] rsp_peak_ff, rsp_peak_in;

   logic              csr_wr;
   logic [SIZE_W-1:0] slots;
   logic              in_acc;
   logic              rd_req;
   logic              wr_keep;
   logic [ADDR_W-1:0] wi_next;
   logic [ADDR_W-1:0] ri_next;
   logic [SIZE_W-1:0] fill_wide;
   logic [ADDR_W-1:0] fill;
   logic [CNT_W-1:0]  want;
   logic [CNT_W-1:0]  n_bytes;
   logic              out_free;
   logic              rd_en;
   logic              load_byte;
   logic              load_empty;

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] idx,
                                                  input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] nx;
      nx = {1'b0, idx} + SIZE_W'(1);
      return (nx == size) ? '0 : nx[ADDR_W-1:0];
   endfunction

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W_TOP] == otrb_pkg::REG_BUF_SIZE);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W_TOP] == otrb_pkg::REG_BUF_SIZE) begin
         csr_prdata = otrb_pkg::CSR_DATA_W'(buf_size_ff);
      end
   end

   assign slots   = (buf_size_ff > SIZE_W'(otrb_pkg::DEPTH)) ? SIZE_W'(otrb_pkg::DEPTH)
                                                            : buf_size_ff;
   assign in_acc  = req_valid && req_ready;
   assign rd_req  = in_acc && (req_type == otrb_pkg::REQ_READ);
   assign wr_keep = in_acc && (req_type == otrb_pkg::REQ_WRITE) && (slots != '0)
                    && otrb_pkg::is_kept(req_char_in);
   assign wi_next = wrap_inc(wi_ff, slots);
   assign ri_next = wrap_inc(ri_ff, slots);

   always_comb begin
      if (wi_ff >= ri_ff) begin
         fill_wide = {1'b0, wi_ff} - {1'b0, ri_ff};
      end else begin
         fill_wide = {1'b0, wi_ff} + slots - {1'b0, ri_ff};
      end
   end
   assign fill = fill_wide[ADDR_W-1:0];

   assign want    = (req_read_count > CNT_W'(otrb_pkg::MAX_READ))
                    ? CNT_W'(otrb_pkg::MAX_READ) : req_read_count;
   assign n_bytes = (fill < ADDR_W'(want)) ? CNT_W'(fill) : want;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         otrb_pkg::ST_IDLE: begin
            if (rd_req) begin
               if ((slots == '0) || (n_bytes == '0)) begin
                  state_in = otrb_pkg::ST_EMPTY;
               end else begin
                  state_in = otrb_pkg::ST_FETCH;
               end
            end
         end
         otrb_pkg::ST_FETCH: begin
            state_in = otrb_pkg::ST_LOAD;
         end
         otrb_pkg::ST_LOAD: begin
            if (out_free && (remain_ff == '0)) begin
               state_in = otrb_pkg::ST_IDLE;
            end
         end
         otrb_pkg::ST_EMPTY: begin
            if (out_free) begin
               state_in = otrb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = otrb_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      load_byte  = 1'b0;
      load_empty = 1'b0;
      case (state_ff)
         otrb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         otrb_pkg::ST_FETCH: begin
            rd_en = 1'b1;
         end
         otrb_pkg::ST_LOAD: begin
            load_byte = out_free;
            // The next byte is fetched as this one moves into the output register.
            rd_en     = out_free && (remain_ff != '0);
         end
         otrb_pkg::ST_EMPTY: begin
            load_empty = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      buf_size_in = buf_size_ff;
      wi_in       = wi_ff;
      ri_in       = ri_ff;
      max_fill_in = max_fill_ff;
      remain_in   = remain_ff;
      if (csr_wr) begin
         buf_size_in = csr_pwdata[SIZE_W-1:0];
         wi_in       = '0;
         ri_in       = '0;
      end else begin
         if (wr_keep) begin
            wi_in = wi_next;
            // A full ring drops its oldest byte.
            if (wi_next == ri_ff) begin
               ri_in = ri_next;
            end
         end
         if (rd_en) begin
            ri_in = ri_next;
         end
      end
      if (rd_req) begin
         remain_in = n_bytes;
         if ((slots != '0) && (PEAK_W'(fill) > max_fill_ff)) begin
            max_fill_in = PEAK_W'(fill);
         end
      end else if (rd_en) begin
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_peak_in   = rsp_peak_ff;
      if (load_byte) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = mem_q_ff;
         rsp_bvalid_in = 1'b1;
         rsp_last_in   = (remain_ff == '0);
         rsp_peak_in   = max_fill_ff;
      end else if (load_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_bvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_peak_in   = max_fill_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= otrb_pkg::ST_IDLE;
         buf_size_ff  <= '0;
         wi_ff        <= '0;
         ri_ff        <= '0;
         max_fill_ff  <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_size_ff  <= buf_size_in;
         wi_ff        <= wi_in;
         ri_ff        <= ri_in;
         max_fill_ff  <= max_fill_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   // Byte memory: writes happen only when idle and reads only while draining,
   // so the two ports never touch the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (wr_keep) begin
         mem[wi_ff] <= req_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[ri_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_peak_fill  = rsp_peak_ff;

endmodule

`default_nettype wire

FILE: design/otrb_checker.sv
`default_nettype none

`include "overwriting_trace_ring_buffer_defines.svh"

module otrb_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          req_type,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [otrb_pkg::CHAR_W-1:0]   rsp_data_out,
   input wire                          rsp_byte_valid,
   input wire                          rsp_last
);

   // A result waiting for the sink must not disappear.
   `OTRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // An empty read result is always the last one of its transaction and carries zero.
   `OTRB_ASSERT_SAME(a_empty_last, clock, reset, rsp_valid && !rsp_byte_valid, rsp_last && (rsp_data_out == '0))

   // A read transaction blocks the input channel in the following cycle.
   `OTRB_ASSERT_NEXT(a_read_blocks, clock, reset, req_valid && req_ready && (req_type == otrb_pkg::REQ_READ), !req_ready)

   // While a read is only partly delivered, no new transaction is taken.
   `OTRB_ASSERT_SAME(a_partial_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)

endmodule

bind overwriting_trace_ring_buffer otrb_checker u_otrb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data_out   (rsp_data_out),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_last       (rsp_last)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int          DEPTH      = otrb_pkg::DEPTH;
   localparam int          SIZE_W     = otrb_pkg::SIZE_W;
   localparam int          MAX_READ   = otrb_pkg::MAX_READ;
   localparam int          CNT_W      = otrb_pkg::CNT_W;
   localparam int          CHAR_W     = otrb_pkg::CHAR_W;
   localparam int          PEAK_W     = otrb_pkg::PEAK_W;
   localparam int          CSR_ADDR_W = otrb_pkg::CSR_ADDR_W;
   localparam int          CSR_DATA_W = otrb_pkg::CSR_DATA_W;
   localparam int          RUN_LIMIT  = 200000;
   localparam int unsigned PEAK_MAX   = (1 << PEAK_W) - 1;
   localparam int          SETTLE_CYC = 4;

   typedef struct packed {
      logic [CHAR_W-1:0] data;
      logic              byte_ok;
      logic              is_last;
      logic [PEAK_W-1:0] peak;
   } trace_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [CHAR_W-1:0]     req_char_in;
   logic [CNT_W-1:0]      req_read_count;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_W-1:0]     rsp_data_out;
   logic                  rsp_byte_valid;
   logic                  rsp_last;
   logic [PEAK_W-1:0]     rsp_peak_fill;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the ring, its pointers, the peak fill and the size register.
   logic [CHAR_W-1:0] ring_mem [0:DEPTH-1];
   int unsigned       head_slot;
   int unsigned       tail_slot;
   int unsigned       peak_seen;
   int unsigned       ring_size;

   trace_beat_type expected_beats[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct;
   int             recv_stall_pct;

   overwriting_trace_ring_buffer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_char_in    (req_char_in),
      .req_read_count (req_read_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_peak_fill  (rsp_peak_fill),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void predict_size_write(input logic [SIZE_W-1:0] value);
      ring_size = value;
      head_slot = 0;
      tail_slot = 0;
   endfunction

   function automatic void push_beat(input logic [CHAR_W-1:0] data, input logic byte_ok,
                                     input logic is_last);
      trace_beat_type beat;
      beat.data    = data;
      beat.byte_ok = byte_ok;
      beat.is_last = is_last;
      beat.peak    = PEAK_W'(peak_seen);
      expected_beats.push_back(beat);
   endfunction

   function automatic void predict_trace_item(input logic kind, input logic [CHAR_W-1:0] ch,
                                              input logic [CNT_W-1:0] want);
      int unsigned slots;
      int unsigned fill;
      int unsigned n;
      slots = (ring_size > DEPTH) ? DEPTH : ring_size;
      if (kind == otrb_pkg::REQ_WRITE) begin
         if (slots != 0 && ((ch >= otrb_pkg::CH_SPACE && ch < otrb_pkg::CH_DEL)
                            || ch == otrb_pkg::CH_NEWLINE)) begin
            ring_mem[head_slot] = ch;
            head_slot = (head_slot + 1) % slots;
            // A full ring drops its oldest byte.
            if (head_slot == tail_slot) begin
               tail_slot = (tail_slot + 1) % slots;
            end
         end
         return;
      end
      fill = 0;
      if (slots != 0) begin
         fill = (head_slot + slots - tail_slot) % slots;
         if (fill > peak_seen) begin
            peak_seen = (fill > PEAK_MAX) ? PEAK_MAX : fill;
         end
      end
      n = (want > MAX_READ) ? MAX_READ : want;
      if (n > fill) begin
         n = fill;
      end
      if (n == 0) begin
         push_beat('0, 1'b0, 1'b1);
         return;
      end
      for (int unsigned i = 0; i < n; i++) begin
         push_beat(ring_mem[tail_slot], 1'b1, (i + 1 == n));
         tail_slot = (tail_slot + 1) % slots;
      end
   endfunction

   // One transaction on the request channel; valid stays high afterwards so that
   // back-to-back items need no second assignment in the same time step.
   task automatic push_trace_item(input logic kind, input logic [CHAR_W-1:0] ch,
                                  input logic [CNT_W-1:0] want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_char_in    <= ch;
      req_read_count <= want;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_trace_item(kind, ch, want);
   endtask

   task automatic write_char(input logic [CHAR_W-1:0] ch);
      push_trace_item(otrb_pkg::REQ_WRITE, ch, CNT_W'($urandom_range(0, 127)));
   endtask

   task automatic read_chars(input logic [CNT_W-1:0] want);
      push_trace_item(otrb_pkg::REQ_READ, CHAR_W'($urandom_range(0, 255)), want);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_buf_size(input logic [SIZE_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({otrb_pkg::REG_BUF_SIZE, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      predict_size_write(value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] random_char();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return CHAR_W'($urandom_range(otrb_pkg::CH_SPACE, otrb_pkg::CH_DEL - 1));
      end else if (pick < 80) begin
         return otrb_pkg::CH_NEWLINE;
      end
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic test_disabled();
      read_chars(CNT_W'(5));
      write_char("A");
      read_chars(CNT_W'(MAX_READ));
   endtask

   task automatic test_size_one();
      write_buf_size(SIZE_W'(1));
      write_char("x");
      read_chars(CNT_W'(3));
   endtask

   task automatic test_char_filter();
      write_buf_size(SIZE_W'(16));
      write_char(otrb_pkg::CH_SPACE);
      write_char(CHAR_W'(otrb_pkg::CH_DEL - 1));
      write_char(otrb_pkg::CH_NEWLINE);
      write_char(otrb_pkg::CH_DEL);
      write_char(CHAR_W'(otrb_pkg::CH_SPACE - 1));
      write_char(8'h00);
      write_char(8'hFF);
      write_char(8'h80);
      write_char(8'h09);
      write_char(8'h0B);
      // A zero count reads as empty even with bytes stored.
      read_chars(CNT_W'(0));
      read_chars(CNT_W'(127));
      read_chars(CNT_W'(1));
   endtask

   task automatic test_overwrite_oldest();
      write_buf_size(SIZE_W'(4));
      for (int i = 0; i < 6; i++) begin
         write_char(CHAR_W'("a" + i));
      end
      read_chars(CNT_W'(2));
      read_chars(CNT_W'(2));
   endtask

   task automatic test_oversize();
      write_buf_size(SIZE_W'((1 << SIZE_W) - 1));
      for (int i = 0; i < 5; i++) begin
         write_char(random_char());
      end
      read_chars(CNT_W'(MAX_READ));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int items);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if ($urandom_range(0, 3) == 0) begin
         write_buf_size(SIZE_W'($urandom_range(17, DEPTH)));
      end else begin
         write_buf_size(SIZE_W'($urandom_range(2, 16)));
      end
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < 70) begin
            write_char(random_char());
         end else if ($urandom_range(0, 3) == 0) begin
            read_chars(CNT_W'($urandom_range(0, 127)));
         end else begin
            read_chars(CNT_W'($urandom_range(0, 16)));
         end
      end
   endtask

   // Fills a small ring past its capacity so that the peak stops at its size less one.
   task automatic test_peak_fill();
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      write_buf_size(SIZE_W'(12));
      for (int i = 0; i < 16; i++) begin
         write_char(CHAR_W'($urandom_range(otrb_pkg::CH_SPACE, otrb_pkg::CH_DEL - 1)));
      end
      read_chars(CNT_W'(5));
      read_chars(CNT_W'(127));
      write_char(otrb_pkg::CH_NEWLINE);
      read_chars(CNT_W'(3));
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      trace_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result: data_out %h byte_valid %b last %b peak_fill %0d",
                   rsp_data_out, rsp_byte_valid, rsp_last, rsp_peak_fill);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data_out !== want.data) begin
               $error("data_out: expected %h, got %h", want.data, rsp_data_out);
               mismatch_count++;
            end
            if (rsp_byte_valid !== want.byte_ok) begin
               $error("byte_valid: expected %b, got %b", want.byte_ok, rsp_byte_valid);
               mismatch_count++;
            end
            if (rsp_last !== want.is_last) begin
               $error("last: expected %b, got %b", want.is_last, rsp_last);
               mismatch_count++;
            end
            if (rsp_peak_fill !== want.peak) begin
               $error("peak_fill: expected %0d, got %0d", want.peak, rsp_peak_fill);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = otrb_pkg::REQ_WRITE;
      req_char_in    = '0;
      req_read_count = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      head_slot      = 0;
      tail_slot      = 0;
      peak_seen      = 0;
      ring_size      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled();
      test_size_one();
      test_char_filter();
      test_overwrite_oldest();
      test_oversize();
      test_peak_fill();
      test_random_traffic(0, 0, 15);
      test_random_traffic(47, 0, 15);
      test_random_traffic(0, 47, 15);
      test_random_traffic(11, 11, 15);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
